/* rtl/alb_pkg.sv */
// Shared types, codes and constants of the ADC ladder button calibrator.
`timescale 1ns / 1ps
package alb_pkg;

  localparam int SAMPLES_PER_LEVEL_DEF = 20;
  localparam int ADC_FULL_SCALE        = 4095;

  localparam int ADC_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int RUN_W      = 4;
  localparam int STEP_W     = 16;
  localparam int SAMPLE_W   = 8;

  localparam logic [RUN_W-1:0]    RUN_MAX    = '1;
  localparam logic [STEP_W-1:0]   STEP_MAX   = '1;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

  localparam logic [15:0] STEP_TIMEOUT_RST    = 16'd10000;
  localparam logic [11:0] GAP_FLOOR_RST       = 12'd100;
  localparam logic [7:0]  SAMPLE_INTERVAL_RST = 8'd50;
  localparam logic [11:0] STAB_WINDOW_RST     = 12'd50;
  localparam logic [3:0]  STABLE_NEEDED_RST   = 4'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_TIMEOUT    = 3'd0,
    CFG_GAP_FLOOR       = 3'd1,
    CFG_SAMPLE_INTERVAL = 3'd2,
    CFG_STAB_WINDOW     = 3'd3,
    CFG_STABLE_NEEDED   = 3'd4
  } alb_cfg_idx_t;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_START  = 2'd1,
    FUNC_CANCEL = 2'd2
  } alb_func_t;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'd0,
    MODE_REST   = 4'd1,
    MODE_B1     = 4'd2,
    MODE_B2     = 4'd3,
    MODE_B3     = 4'd4,
    MODE_CHECK  = 4'd5,
    MODE_COMMIT = 4'd6,
    MODE_DONE   = 4'd7,
    MODE_ERROR  = 4'd8
  } alb_mode_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_REST  = 3'd1,
    PH_B1    = 3'd2,
    PH_B2    = 3'd3,
    PH_B3    = 3'd4,
    PH_DONE  = 3'd5,
    PH_ERROR = 3'd6
  } alb_phase_t;

  typedef enum logic [3:0] {
    EV_NONE        = 4'd0,
    EV_STARTED     = 4'd1,
    EV_TIMEOUT     = 4'd2,
    EV_SAMPLING    = 4'd3,
    EV_OUTLIER     = 4'd4,
    EV_TOO_CLOSE   = 4'd5,
    EV_NEXT_BUTTON = 4'd6,
    EV_COMPUTING   = 4'd7,
    EV_BAD_LEVELS  = 4'd8,
    EV_COMPLETE    = 4'd9
  } alb_event_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [ADC_W-1:0] adc_sample;
  } alb_in_t;

  typedef struct packed {
    logic [2:0]       phase;
    logic [ADC_W-1:0] live_adc;
    logic [3:0]       event_code;
    logic             start_accepted;
    logic [ADC_W-1:0] btn1_low;
    logic [ADC_W-1:0] btn1_high;
    logic [ADC_W-1:0] btn2_low;
    logic [ADC_W-1:0] btn2_high;
    logic [ADC_W-1:0] btn3_low;
    logic             thresholds_valid;
  } alb_out_t;

  typedef struct packed {
    logic [15:0] step_timeout_ticks;
    logic [11:0] gap_floor;
    logic [7:0]  sample_interval_ticks;
    logic [11:0] settle_band;
    logic [3:0]  stable_needed;
  } alb_cfg_t;

  // Level check verdict and the three distinct midpoints.
  typedef struct packed {
    logic             levels_ok;
    logic [ADC_W-1:0] mid_rest_b1;
    logic [ADC_W-1:0] mid_b1_b2;
    logic [ADC_W-1:0] mid_b2_b3;
  } alb_lvl_t;

endpackage

/* rtl/alb_cfg.sv */
// Configuration register file of the calibrator.
`timescale 1ns / 1ps
module alb_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [alb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [alb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output alb_pkg::alb_cfg_t               cfg
);
  import alb_pkg::*;

  alb_cfg_t cfg_r;
  alb_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_TIMEOUT:    cfg_nxt.step_timeout_ticks    = cfg_wdata;
        CFG_GAP_FLOOR:       cfg_nxt.gap_floor             = cfg_wdata[11:0];
        CFG_SAMPLE_INTERVAL: cfg_nxt.sample_interval_ticks = cfg_wdata[7:0];
        CFG_STAB_WINDOW:     cfg_nxt.settle_band           = cfg_wdata[11:0];
        CFG_STABLE_NEEDED:   cfg_nxt.stable_needed         = cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_timeout_ticks    <= STEP_TIMEOUT_RST;
      cfg_r.gap_floor             <= GAP_FLOOR_RST;
      cfg_r.sample_interval_ticks <= SAMPLE_INTERVAL_RST;
      cfg_r.settle_band           <= STAB_WINDOW_RST;
      cfg_r.stable_needed         <= STABLE_NEEDED_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/alb_levels.sv */
// Ascending-level check and midpoint thresholds over the four measured levels.
`timescale 1ns / 1ps
module alb_levels (
  input  logic [3:0][alb_pkg::ADC_W-1:0] levels,
  input  logic [alb_pkg::ADC_W-1:0]      min_gap,
  output alb_pkg::alb_lvl_t              lvl
);
  import alb_pkg::*;

  logic [ADC_W-1:0] r0, s1, s2, s3;
  logic             ascending, gaps_ok, in_range;
  logic [ADC_W:0]   sum_01, sum_12, sum_23;

  assign r0 = levels[0];
  assign s1 = levels[1];
  assign s2 = levels[2];
  assign s3 = levels[3];

  assign ascending = (r0 < s1) && (s1 < s2) && (s2 < s3);
  // Differences only matter once the order holds, so plain unsigned subtraction is enough.
  assign gaps_ok   = ((s1 - r0) >= min_gap) && ((s2 - s1) >= min_gap) &&
                     ((s3 - s2) >= min_gap);
  assign in_range  = ({4'b0, s3} <= 16'(ADC_FULL_SCALE));

  assign sum_01 = {1'b0, r0} + {1'b0, s1};
  assign sum_12 = {1'b0, s1} + {1'b0, s2};
  assign sum_23 = {1'b0, s2} + {1'b0, s3};

  assign lvl.levels_ok   = ascending && gaps_ok && in_range;
  assign lvl.mid_rest_b1 = sum_01[ADC_W:1];
  assign lvl.mid_b1_b2   = sum_12[ADC_W:1];
  assign lvl.mid_b2_b3   = sum_23[ADC_W:1];

endmodule

/* rtl/alb_core.sv */
// Calibration sequencer: state registers and the single-pass step logic.
`timescale 1ns / 1ps
module alb_core #(
  parameter int SAMPLES_PER_LEVEL = alb_pkg::SAMPLES_PER_LEVEL_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  alb_pkg::alb_in_t  word,
  input  alb_pkg::alb_cfg_t cfg,
  output alb_pkg::alb_out_t result
);
  import alb_pkg::*;

  localparam int CLN   = $clog2(SAMPLES_PER_LEVEL);
  localparam int TW    = ADC_W + CLN;
  localparam int CW    = $clog2(SAMPLES_PER_LEVEL + 1);
  // Average by reciprocal: floor(x / N) == (x * ceil(2^SH / N)) >> SH for x < 2^TW.
  localparam int SH    = TW + CLN;
  localparam int RECIP = ((1 << SH) + SAMPLES_PER_LEVEL - 1) / SAMPLES_PER_LEVEL;
  localparam int RW    = $clog2(RECIP + 1);

  localparam logic [CW-1:0] TAKEN_FULL = CW'(SAMPLES_PER_LEVEL);
  localparam logic [RW-1:0] RECIP_V    = RW'(RECIP);

  alb_mode_t               mode_r, mode_nxt;
  logic                    sampling_r, sampling_nxt;
  logic [RUN_W-1:0]        run_r, run_nxt;
  logic [ADC_W-1:0]        last_r, last_nxt;
  logic [STEP_W-1:0]       step_el_r, step_el_nxt;
  logic [SAMPLE_W-1:0]     samp_el_r, samp_el_nxt;
  logic [TW-1:0]           total_r, total_nxt;
  logic [CW-1:0]           taken_r, taken_nxt;
  logic [3:0][ADC_W-1:0]   levels_r, levels_nxt;
  logic [ADC_W-1:0]        thr_lo_r, thr_lo_nxt;
  logic [ADC_W-1:0]        thr_mid_r, thr_mid_nxt;
  logic [ADC_W-1:0]        thr_hi_r, thr_hi_nxt;
  logic [ADC_W-1:0]        live_r, live_nxt;

  alb_lvl_t                lvl;
  logic                    running;
  logic [ADC_W-1:0]        rd;
  logic [1:0]              idx;
  logic                    has_prev;
  logic [ADC_W:0]          prev_plus_gap;
  logic [ADC_W:0]          rd_plus_win;
  logic [ADC_W:0]          last_plus_win;
  logic [STEP_W-1:0]       step_el_inc;
  logic [SAMPLE_W-1:0]     samp_el_inc;
  logic                    above;
  logic                    run_hit;
  logic [RUN_W-1:0]        run_new;
  logic                    outlier;
  logic [TW-1:0]           total_sum;
  logic [CW-1:0]           taken_inc;
  logic [TW+RW-1:0]        avg_prod;
  logic [ADC_W-1:0]        avg;
  logic                    too_close;
  alb_event_t              ev;
  logic                    accepted;
  logic                    thr_valid;
  alb_phase_t              phase;

  alb_levels u_levels (
    .levels  (levels_r),
    .min_gap (cfg.gap_floor),
    .lvl     (lvl)
  );

  assign rd       = word.adc_sample;
  assign running  = (mode_r != MODE_IDLE) && (mode_r != MODE_DONE) &&
                    (mode_r != MODE_ERROR);
  assign idx      = 2'(4'(mode_r) - 4'(MODE_REST));
  assign has_prev = (mode_r != MODE_REST);

  assign prev_plus_gap = {1'b0, levels_r[2'(idx - 2'd1)]} + {1'b0, cfg.gap_floor};
  assign rd_plus_win   = {1'b0, rd} + {1'b0, cfg.settle_band};
  assign last_plus_win = {1'b0, last_r} + {1'b0, cfg.settle_band};

  assign step_el_inc = (step_el_r != STEP_MAX) ? step_el_r + 1'b1 : step_el_r;
  assign samp_el_inc = (samp_el_r != SAMPLE_MAX) ? samp_el_r + 1'b1 : samp_el_r;

  // Wait phase: a reading counts when at least the gap above the previous level;
  // later readings of a run must also lie strictly inside the last one's window.
  assign above   = !has_prev || ({1'b0, rd} >= prev_plus_gap);
  assign run_hit = above && ((run_r == '0) ||
                   ((rd_plus_win > {1'b0, last_r}) && ({1'b0, rd} < last_plus_win)));
  assign run_new = !run_hit ? '0 : (run_r == RUN_MAX) ? run_r : run_r + 1'b1;

  // Sample phase: outlier when outside the inclusive window.
  assign outlier   = (rd_plus_win < {1'b0, last_r}) || ({1'b0, rd} > last_plus_win);
  assign total_sum = total_r + TW'(rd);
  assign taken_inc = taken_r + 1'b1;
  assign avg_prod  = TW'(total_sum) * RECIP_V;
  assign avg       = avg_prod[SH +: ADC_W];
  assign too_close = has_prev && ({1'b0, avg} < prev_plus_gap);

  always_comb begin
    mode_nxt     = mode_r;
    sampling_nxt = sampling_r;
    run_nxt      = run_r;
    last_nxt     = last_r;
    step_el_nxt  = step_el_r;
    samp_el_nxt  = samp_el_r;
    total_nxt    = total_r;
    taken_nxt    = taken_r;
    levels_nxt   = levels_r;
    thr_lo_nxt   = thr_lo_r;
    thr_mid_nxt  = thr_mid_r;
    thr_hi_nxt   = thr_hi_r;
    live_nxt     = live_r;
    ev           = EV_NONE;
    accepted     = 1'b0;
    thr_valid    = 1'b0;

    case (word.func)
      FUNC_START: begin
        if (!running) begin
          levels_nxt   = '0;
          live_nxt     = '0;
          mode_nxt     = MODE_REST;
          step_el_nxt  = '0;
          sampling_nxt = 1'b0;
          run_nxt      = '0;
          last_nxt     = '0;
          samp_el_nxt  = '0;
          accepted     = 1'b1;
          ev           = EV_STARTED;
        end
      end
      FUNC_CANCEL: begin
        if (mode_r != MODE_IDLE) begin
          levels_nxt   = '0;
          live_nxt     = '0;
          mode_nxt     = MODE_IDLE;
          sampling_nxt = 1'b0;
          run_nxt      = '0;
        end
      end
      FUNC_TICK: begin
        if (running) begin
          live_nxt = rd;
          case (mode_r)
            MODE_REST, MODE_B1, MODE_B2, MODE_B3: begin
              step_el_nxt = step_el_inc;
              if (!sampling_r) begin
                if (step_el_inc >= cfg.step_timeout_ticks) begin
                  step_el_nxt = '0;
                  run_nxt     = '0;
                  ev          = EV_TIMEOUT;
                end else begin
                  run_nxt  = run_new;
                  last_nxt = rd;
                  if (run_new >= cfg.stable_needed) begin
                    sampling_nxt = 1'b1;
                    taken_nxt    = '0;
                    total_nxt    = '0;
                    samp_el_nxt  = '0;
                    ev           = EV_SAMPLING;
                  end
                end
              end else begin
                samp_el_nxt = samp_el_inc;
                if (samp_el_inc >= cfg.sample_interval_ticks) begin
                  samp_el_nxt = '0;
                  if (outlier) begin
                    sampling_nxt = 1'b0;
                    run_nxt      = '0;
                    ev           = EV_OUTLIER;
                  end else begin
                    total_nxt = total_sum;
                    taken_nxt = taken_inc;
                    if (taken_inc >= TAKEN_FULL) begin
                      sampling_nxt = 1'b0;
                      run_nxt      = '0;
                      step_el_nxt  = '0;
                      if (too_close) begin
                        ev = EV_TOO_CLOSE;
                      end else begin
                        levels_nxt[idx] = avg;
                        last_nxt        = '0;
                        if (mode_r == MODE_B3) begin
                          mode_nxt = MODE_CHECK;
                          ev       = EV_COMPUTING;
                        end else begin
                          mode_nxt = alb_mode_t'(4'(mode_r) + 4'd1);
                          ev       = EV_NEXT_BUTTON;
                        end
                      end
                    end
                  end
                end
              end
            end
            MODE_CHECK: begin
              if (lvl.levels_ok) begin
                mode_nxt = MODE_COMMIT;
              end else begin
                mode_nxt = MODE_ERROR;
                ev       = EV_BAD_LEVELS;
              end
            end
            MODE_COMMIT: begin
              thr_lo_nxt  = lvl.mid_rest_b1;
              thr_mid_nxt = lvl.mid_b1_b2;
              thr_hi_nxt  = lvl.mid_b2_b3;
              mode_nxt    = MODE_DONE;
              thr_valid   = 1'b1;
              ev          = EV_COMPLETE;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    case (mode_nxt)
      MODE_IDLE:                            phase = PH_IDLE;
      MODE_REST:                            phase = PH_REST;
      MODE_B1:                              phase = PH_B1;
      MODE_B2:                              phase = PH_B2;
      MODE_B3, MODE_CHECK, MODE_COMMIT:     phase = PH_B3;
      MODE_DONE:                            phase = PH_DONE;
      MODE_ERROR:                           phase = PH_ERROR;
      default:                              phase = PH_IDLE;
    endcase
  end

  assign result.phase            = phase;
  assign result.live_adc         = live_nxt;
  assign result.event_code       = ev;
  assign result.start_accepted   = accepted;
  assign result.btn1_low         = thr_lo_nxt;
  assign result.btn1_high        = thr_mid_nxt;
  assign result.btn2_low         = thr_mid_nxt;
  assign result.btn2_high        = thr_hi_nxt;
  assign result.btn3_low         = thr_hi_nxt;
  assign result.thresholds_valid = thr_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      sampling_r <= 1'b0;
      run_r      <= '0;
      last_r     <= '0;
      step_el_r  <= '0;
      samp_el_r  <= '0;
      total_r    <= '0;
      taken_r    <= '0;
      levels_r   <= '0;
      thr_lo_r   <= '0;
      thr_mid_r  <= '0;
      thr_hi_r   <= '0;
      live_r     <= '0;
    end else if (step_en) begin
      mode_r     <= mode_nxt;
      sampling_r <= sampling_nxt;
      run_r      <= run_nxt;
      last_r     <= last_nxt;
      step_el_r  <= step_el_nxt;
      samp_el_r  <= samp_el_nxt;
      total_r    <= total_nxt;
      taken_r    <= taken_nxt;
      levels_r   <= levels_nxt;
      thr_lo_r   <= thr_lo_nxt;
      thr_mid_r  <= thr_mid_nxt;
      thr_hi_r   <= thr_hi_nxt;
      live_r     <= live_nxt;
    end
  end

  a_sampling_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    sampling_r |-> (mode_r == MODE_REST || mode_r == MODE_B1 ||
                    mode_r == MODE_B2 || mode_r == MODE_B3))
    else $error("sampling flag set outside a measuring step");

  a_taken_below_full: assert property (@(posedge clk) disable iff (!rst_n)
    sampling_r |-> (taken_r < TAKEN_FULL))
    else $error("sample count reached full while still sampling");

  a_start_enters_rest: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && word.func == FUNC_START && !running) |=> (mode_r == MODE_REST))
    else $error("accepted start did not enter the resting step");

  a_commit_from_check: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && mode_r == MODE_COMMIT && word.func == FUNC_TICK) |->
      (lvl.levels_ok && thr_valid))
    else $error("commit reached with levels that fail the check");

endmodule

/* rtl/adc_ladder_button_calibrator.sv */
// Top level of the ADC ladder button calibrator: word registers around the sequencer.
`timescale 1ns / 1ps
// Flow: an accepted word waits in the input register and is processed into the result
//   register once that register is free or being emptied.
// Throughput: one word per cycle while the output is not stalled.
// Reset: synchronous, active low; empties both word registers, the sequencer to idle,
//   the thresholds to zero and the configuration registers to their defaults.
module adc_ladder_button_calibrator #(
  parameter int SAMPLES_PER_LEVEL = alb_pkg::SAMPLES_PER_LEVEL_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  alb_pkg::alb_in_t                in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output alb_pkg::alb_out_t               out_word,
  input  logic                            cfg_we,
  input  logic [alb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [alb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import alb_pkg::*;

  logic     in_valid_r, in_valid_nxt;
  alb_in_t  in_word_r;
  logic     out_valid_r, out_valid_nxt;
  alb_out_t out_word_r;
  logic     advance;
  alb_cfg_t cfg;
  alb_out_t result;

  alb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Advance the held word into the sequencer whenever the result register is
  // free or being emptied this cycle.
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  // Stall the input only when the held word cannot move on.
  assign in_stall = in_valid_r && !advance;

  assign in_valid_nxt  = in_stall ? 1'b1 : in_valid;
  assign out_valid_nxt = advance ? 1'b1 : (out_valid_r && out_stall);

  alb_core #(
    .SAMPLES_PER_LEVEL (SAMPLES_PER_LEVEL)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .word    (in_word_r),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: load on a handshake, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_word_r <= in_word;
    end
    if (advance) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_stall_needs_full_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled while the result register could take a word");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed word did not reach the result register");

  a_held_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> in_valid_r)
    else $error("held word dropped without being processed");

endmodule

/* test/tb_adc_ladder_button_calibrator.sv */
// Self-checking testbench for the ADC ladder button calibrator: directed and random words.
`timescale 1ns / 1ps
module tb_adc_ladder_button_calibrator;
  import alb_pkg::*;

  // Hard ceiling on the run; far above the slowest legal run with every stall mode.
  localparam int CYCLE_LIMIT = 400000;
  // Stop sending calibration traffic once this many words have gone in.
  localparam int WORD_TARGET = 1420;
  // The one func code the block must ignore.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef enum int {
    FLOW_FREE,
    FLOW_SEND_GAPS,
    FLOW_RECV_STALLS,
    FLOW_BOTH
  } flow_t;

  // Mirror of the calibrator: tracks its state word by word and holds the
  // result words still awaited from the block.
  class ladder_calib_mirror;
    alb_cfg_t            cfg;
    alb_mode_t           mode;
    bit                  sampling;
    logic [RUN_W-1:0]    stable_run;
    logic [ADC_W-1:0]    last_reading;
    logic [STEP_W-1:0]   step_elapsed;
    logic [SAMPLE_W-1:0] sample_elapsed;
    int unsigned         sample_total;
    int unsigned         samples_taken;
    logic [ADC_W-1:0]    levels [4];
    logic [ADC_W-1:0]    thresholds [5];
    logic [ADC_W-1:0]    live_adc;
    alb_out_t            awaited_words [$];
    int                  errors;

    function new();
      cfg.step_timeout_ticks    = STEP_TIMEOUT_RST;
      cfg.gap_floor             = GAP_FLOOR_RST;
      cfg.sample_interval_ticks = SAMPLE_INTERVAL_RST;
      cfg.settle_band           = STAB_WINDOW_RST;
      cfg.stable_needed         = STABLE_NEEDED_RST;
      mode           = MODE_IDLE;
      sampling       = 1'b0;
      stable_run     = '0;
      last_reading   = '0;
      step_elapsed   = '0;
      sample_elapsed = '0;
      sample_total   = 0;
      samples_taken  = 0;
      foreach (levels[i]) levels[i] = '0;
      foreach (thresholds[i]) thresholds[i] = '0;
      live_adc = '0;
      errors   = 0;
    endfunction

    function void write_reg(alb_cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_STEP_TIMEOUT:    cfg.step_timeout_ticks    = value;
        CFG_GAP_FLOOR:       cfg.gap_floor             = value[11:0];
        CFG_SAMPLE_INTERVAL: cfg.sample_interval_ticks = value[7:0];
        CFG_STAB_WINDOW:     cfg.settle_band           = value[11:0];
        CFG_STABLE_NEEDED:   cfg.stable_needed         = value[3:0];
        default: ;
      endcase
    endfunction

    function bit running();
      return mode != MODE_IDLE && mode != MODE_DONE && mode != MODE_ERROR;
    endfunction

    // Level the calibration is currently measuring, 0 for resting.
    function int level_slot();
      case (mode)
        MODE_REST, MODE_B1, MODE_B2, MODE_B3: return int'(mode) - int'(MODE_REST);
        default: return 3;
      endcase
    endfunction

    function void enter_step(alb_mode_t m);
      mode           = m;
      step_elapsed   = '0;
      sampling       = 1'b0;
      stable_run     = '0;
      last_reading   = '0;
      sample_elapsed = '0;
    endfunction

    // One tick inside a measuring step: wait phase, then sample phase.
    function alb_event_t advance_level(logic [ADC_W-1:0] rd);
      int               slot;
      int               below;
      int               r;
      int               last;
      int               win;
      int               gap;
      bit               has_below;
      bit               above;
      logic [ADC_W-1:0] avg;
      slot      = level_slot();
      has_below = (mode != MODE_REST);
      below     = has_below ? int'(levels[(slot - 1) & 3]) : 0;
      r         = rd;
      last      = last_reading;
      win       = cfg.settle_band;
      gap       = cfg.gap_floor;

      // The step timer runs in both phases and saturates.
      if (step_elapsed != STEP_MAX) step_elapsed++;

      if (!sampling) begin
        if (step_elapsed >= cfg.step_timeout_ticks) begin
          step_elapsed = '0;
          stable_run   = '0;
          return EV_TIMEOUT;
        end
        above = !has_below || r >= below + gap;
        if (above && (stable_run == 0 || (r > last - win && r < last + win))) begin
          if (stable_run != RUN_MAX) stable_run++;
        end else begin
          stable_run = '0;
        end
        last_reading = rd;
        if (stable_run >= cfg.stable_needed) begin
          sampling       = 1'b1;
          samples_taken  = 0;
          sample_total   = 0;
          sample_elapsed = '0;
          return EV_SAMPLING;
        end
        return EV_NONE;
      end

      if (sample_elapsed != SAMPLE_MAX) sample_elapsed++;
      if (sample_elapsed < cfg.sample_interval_ticks) return EV_NONE;
      sample_elapsed = '0;
      // Outlier: back to the wait phase, timer left running.
      if (r < last - win || r > last + win) begin
        sampling   = 1'b0;
        stable_run = '0;
        return EV_OUTLIER;
      end
      sample_total += rd;
      samples_taken++;
      if (samples_taken >= SAMPLES_PER_LEVEL_DEF) begin
        avg          = ADC_W'(sample_total / SAMPLES_PER_LEVEL_DEF);
        sampling     = 1'b0;
        stable_run   = '0;
        step_elapsed = '0;
        if (has_below && int'(avg) < below + gap) return EV_TOO_CLOSE;
        levels[slot & 3] = avg;
        if (mode == MODE_B3) begin
          enter_step(MODE_CHECK);
          return EV_COMPUTING;
        end
        enter_step(alb_mode_t'(mode + 1));
        return EV_NEXT_BUTTON;
      end
      return EV_NONE;
    endfunction

    // Accepted input word: advance the mirror and queue the result it causes.
    function void note_word(alb_in_t w);
      alb_out_t   o;
      alb_event_t ev;
      int         r0;
      int         s1;
      int         s2;
      int         s3;
      int         gap;
      o   = '0;
      ev  = EV_NONE;
      r0  = levels[0];
      s1  = levels[1];
      s2  = levels[2];
      s3  = levels[3];
      gap = cfg.gap_floor;
      case (w.func)
        FUNC_START: begin
          if (!running()) begin
            foreach (levels[i]) levels[i] = '0;
            live_adc = '0;
            enter_step(MODE_REST);
            o.start_accepted = 1'b1;
            ev = EV_STARTED;
          end
        end
        FUNC_CANCEL: begin
          if (mode != MODE_IDLE) begin
            foreach (levels[i]) levels[i] = '0;
            live_adc   = '0;
            mode       = MODE_IDLE;
            sampling   = 1'b0;
            stable_run = '0;
          end
        end
        FUNC_TICK: begin
          if (running()) begin
            live_adc = w.adc_sample;
            case (mode)
              MODE_CHECK: begin
                if (!(r0 < s1 && s1 < s2 && s2 < s3) || s1 - r0 < gap || s2 - s1 < gap ||
                    s3 - s2 < gap || s3 > ADC_FULL_SCALE) begin
                  mode = MODE_ERROR;
                  ev   = EV_BAD_LEVELS;
                end else begin
                  mode = MODE_COMMIT;
                end
              end
              MODE_COMMIT: begin
                thresholds[0] = ADC_W'((r0 + s1) / 2);
                thresholds[1] = ADC_W'((s1 + s2) / 2);
                thresholds[2] = ADC_W'((s1 + s2) / 2);
                thresholds[3] = ADC_W'((s2 + s3) / 2);
                thresholds[4] = ADC_W'((s2 + s3) / 2);
                mode = MODE_DONE;
                o.thresholds_valid = 1'b1;
                ev = EV_COMPLETE;
              end
              default: ev = advance_level(w.adc_sample);
            endcase
          end
        end
        default: ;
      endcase

      case (mode)
        MODE_IDLE:               o.phase = PH_IDLE;
        MODE_DONE:               o.phase = PH_DONE;
        MODE_ERROR:              o.phase = PH_ERROR;
        MODE_CHECK, MODE_COMMIT: o.phase = PH_B3;
        default:                 o.phase = mode[2:0];
      endcase
      o.live_adc   = live_adc;
      o.event_code = ev;
      o.btn1_low   = thresholds[0];
      o.btn1_high  = thresholds[1];
      o.btn2_low   = thresholds[2];
      o.btn2_high  = thresholds[3];
      o.btn3_low   = thresholds[4];
      awaited_words.push_back(o);
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    // Accepted result word: compare with the oldest awaited one.
    function void check_word(alb_out_t got);
      alb_out_t want;
      if (awaited_words.size() == 0) begin
        $error("result word arrived with nothing awaited");
        errors++;
        return;
      end
      want = awaited_words.pop_front();
      compare("phase", want.phase, got.phase);
      compare("live_adc", want.live_adc, got.live_adc);
      compare("event_code", want.event_code, got.event_code);
      compare("start_accepted", want.start_accepted, got.start_accepted);
      compare("btn1_low", want.btn1_low, got.btn1_low);
      compare("btn1_high", want.btn1_high, got.btn1_high);
      compare("btn2_low", want.btn2_low, got.btn2_low);
      compare("btn2_high", want.btn2_high, got.btn2_high);
      compare("btn3_low", want.btn3_low, got.btn3_low);
      compare("thresholds_valid", want.thresholds_valid, got.thresholds_valid);
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  alb_in_t               in_word   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  alb_out_t              out_word;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  ladder_calib_mirror sb;

  // Current flow control and the settings the stimulus shapes its levels on.
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int close_pct      = 20;
  int ph_gap         = GAP_FLOOR_RST;
  int ph_interval    = SAMPLE_INTERVAL_RST;
  int ph_window      = STAB_WINDOW_RST;
  int ph_need        = STABLE_NEEDED_RST;
  int words_sent     = 0;
  int cycle_count    = 0;
  bit paused_once    = 1'b0;

  adc_ladder_button_calibrator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Abandon the run if it hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_adc_ladder_button_calibrator failed");
      $finish;
    end
  end

  // Receiver side: stall at random according to the current flow mode.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watch both channels; values read here are the ones present before the edge.
  // Note the input first so an expectation is always queued ahead of its result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_word(in_word);
      if (out_valid && !out_stall) sb.check_word(out_word);
    end
  end

  task automatic set_flow(flow_t f);
    case (f)
      FLOW_FREE:        begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      FLOW_SEND_GAPS:   begin send_gap_pct = 54; recv_stall_pct = 0;  end
      FLOW_RECV_STALLS: begin send_gap_pct = 0;  recv_stall_pct = 54; end
      default:          begin send_gap_pct = 14; recv_stall_pct = 14; end
    endcase
  endtask

  // Offer one word and hold it until taken. Leave valid high on return: the
  // caller either offers the next word or drops valid at this same edge.
  task automatic send_word(logic [1:0] fn, logic [ADC_W-1:0] adc);
    alb_in_t w;
    w.func       = fn;
    w.adc_sample = adc;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Drop valid and wait until every awaited result has come out, plus a little margin.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(alb_cfg_idx_t idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    sb.write_reg(idx, value[CFG_DATA_W-1:0]);
  endtask

  // Rewrite every register with the block idle.
  task automatic configure(int timeout, int gap, int interval, int window, int need);
    drain();
    write_cfg(CFG_STEP_TIMEOUT, timeout);
    write_cfg(CFG_GAP_FLOOR, gap);
    write_cfg(CFG_SAMPLE_INTERVAL, interval);
    write_cfg(CFG_STAB_WINDOW, window);
    write_cfg(CFG_STABLE_NEEDED, need);
    cfg_we <= 1'b0;
    @(posedge clk);
    ph_gap      = gap;
    ph_interval = interval;
    ph_window   = window;
    ph_need     = need;
  endtask

  // Idle behaviour, refused and ignored commands, cancel, reading extremes.
  task automatic run_directed();
    send_word(FUNC_CANCEL, 12'h000);
    send_word(FUNC_TICK, 12'hFFF);
    send_word(FUNC_UNUSED, 12'hFFF);
    send_word(FUNC_START, 12'h000);
    send_word(FUNC_START, 12'hABC);
    send_word(FUNC_UNUSED, 12'h555);
    send_word(FUNC_TICK, 12'h000);
    // a jump to full scale breaks the run; then three steady readings start sampling
    repeat (4) send_word(FUNC_TICK, 12'hFFF);
    send_word(FUNC_TICK, 12'hFFF);
    send_word(FUNC_CANCEL, 12'h000);
    send_word(FUNC_CANCEL, 12'hFFF);
    send_word(FUNC_START, 12'h000);
    repeat (4) send_word(FUNC_TICK, 12'h000);
    send_word(FUNC_TICK, 12'hFFF);
    send_word(FUNC_CANCEL, 12'h000);
  endtask

  // One calibration attempt: plan four ascending levels, then present readings
  // around the level the block is measuring, with some noise and stray commands.
  task automatic run_calibration(int tick_cap);
    int plan [4];
    int spacing [3];
    int span;
    int jit;
    int ticks;
    int pick;
    int rd;
    jit = (ph_window >= 2) ? (ph_window - 1) / 2 : 0;
    if (jit > 15) jit = 15;
    span = 0;
    foreach (spacing[i]) begin
      // Now and then plan a level too close, to provoke rejects and bad levels.
      if ($urandom_range(99) < close_pct) spacing[i] = $urandom_range(ph_gap + jit);
      else spacing[i] = ph_gap + 2 * jit + 1 + $urandom_range(40);
      span += spacing[i];
    end
    plan[0] = ($urandom_range(99) < 15 || span >= 4095) ? 0 : $urandom_range(4095 - span);
    for (int i = 1; i < 4; i++) begin
      plan[i] = plan[i-1] + spacing[i-1];
      if (plan[i] > 4095) plan[i] = 4095;
    end

    send_word(FUNC_START, ADC_W'($urandom_range(4095)));
    ticks = 0;
    while (ticks < tick_cap && sb.running() && words_sent < WORD_TARGET) begin
      pick = $urandom_range(199);
      if (pick == 0) begin
        send_word(FUNC_START, ADC_W'($urandom_range(4095)));
      end else if (pick == 1) begin
        send_word(FUNC_UNUSED, ADC_W'($urandom_range(4095)));
      end else if (pick == 2) begin
        send_word(FUNC_CANCEL, ADC_W'($urandom_range(4095)));
      end else if (pick < 7) begin
        send_word(FUNC_TICK, ADC_W'($urandom_range(4095)));
      end else begin
        rd = plan[sb.level_slot()] - jit + int'($urandom_range(2 * jit));
        if (rd < 0) rd = 0;
        if (rd > 4095) rd = 4095;
        send_word(FUNC_TICK, rd[ADC_W-1:0]);
      end
      ticks++;
      // Hold off once mid-calibration until the block has emptied.
      if (!paused_once && ticks == 10) begin
        drain();
        paused_once = 1'b1;
      end
    end
    // Leave done or error behind now and then, so a fresh start follows it.
    if (sb.running() || $urandom_range(1) == 0) begin
      send_word(FUNC_CANCEL, ADC_W'($urandom_range(4095)));
    end
  endtask

  function automatic int calib_cap(int need, int interval);
    int per_level;
    per_level = need + 3 + 20 * ((interval > 1) ? interval : 1);
    return (4 * per_level + 40 > 2000) ? 2000 : 4 * per_level + 40;
  endfunction

  initial begin
    int phase_no;
    int timeout;
    int gap;
    int interval;
    int window;
    int need;
    sb = new();
    set_flow(FLOW_FREE);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults first.
    run_directed();

    // Moderate settings, no idling; the mid-run hold-off happens here.
    configure(200, 100, 1, 50, 3);
    repeat (2) run_calibration(calib_cap(3, 1));

    // Zero timeout: every wait tick times out.
    set_flow(FLOW_SEND_GAPS);
    configure(0, 0, 0, 1, 0);
    run_calibration(12);

    // Longest timeout, no gap, zero window, zero interval, zero run length;
    // equal levels end in bad levels.
    set_flow(FLOW_RECV_STALLS);
    close_pct = 50;
    configure(65535, 0, 0, 0, 0);
    repeat (3) run_calibration(calib_cap(0, 0));
    close_pct = 20;

    // Widest gap and longest run: only a zero rest and full-scale button fit.
    set_flow(FLOW_BOTH);
    configure(40, 4095, 1, 1, 15);
    run_calibration(250);

    // Slowest interval and widest window: reach the first samples only.
    set_flow(FLOW_FREE);
    configure(30, 300, 255, 4095, 1);
    run_calibration(300);

    // Random settings, cycling through the flow modes.
    phase_no = 0;
    while (words_sent < WORD_TARGET) begin
      phase_no++;
      set_flow(flow_t'(phase_no % 4));
      timeout  = ($urandom_range(3) == 0) ? $urandom_range(65535, 1) : $urandom_range(400, 15);
      gap      = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(300);
      interval = ($urandom_range(7) == 0) ? $urandom_range(20) : $urandom_range(3);
      window   = ($urandom_range(4) == 0) ? $urandom_range(4095) : $urandom_range(80);
      need     = $urandom_range(15);
      close_pct = ($urandom_range(1) == 0) ? 10 : 30;
      configure(timeout, gap, interval, window, need);
      repeat ($urandom_range(3, 1)) run_calibration(calib_cap(need, interval));
    end

    drain();
    if (sb.errors == 0 && sb.awaited_words.size() == 0) begin
      $display("tb_adc_ladder_button_calibrator passed");
    end else begin
      $display("tb_adc_ladder_button_calibrator failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/alb_pkg.sv
rtl/alb_cfg.sv
rtl/alb_levels.sv
rtl/alb_core.sv
rtl/adc_ladder_button_calibrator.sv
test/tb_adc_ladder_button_calibrator.sv
